/* rtl/core/srm_pkg.sv */
package srm_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int SEQ_W           = 32;
    localparam int DSEQ_W          = 64;
    localparam int LEN_W           = 16;
    localparam int ACTION_W        = 2;
    localparam int COUNT_OUT_W     = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  start;
        logic [DSEQ_W-1:0] dseq;
        logic [LEN_W-1:0]  len;
    } entry_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              insert_en;
        logic              lookup_en;
        logic              head_first;
        logic [SEQ_W-1:0]  seq;
        entry_t            new_entry;
    } cell_ctl_t;

endpackage

/* rtl/core/srm_cell.sv */
module srm_cell #(
    parameter int Idx    = 0,
    parameter int CountW = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  srm_pkg::cell_ctl_t          ctl,
    input  logic [CountW-1:0]           count,
    input  srm_pkg::entry_t             prev_entry,
    input  logic                        prev_ge,
    output logic                        ge,
    output srm_pkg::entry_t             entry,
    input  logic                        prior_in,
    output logic                        prior_out,
    output logic [srm_pkg::DSEQ_W-1:0]  sel_value
);

    srm_pkg::entry_t                entry_reg;
    logic                           hit_reg;
    logic                           hit_next;
    logic [srm_pkg::DSEQ_W-1:0]     mapped_reg;
    logic                           valid;
    logic [srm_pkg::SEQ_W-1:0]      range_end;
    logic [srm_pkg::SEQ_W-1:0]      diff;

    assign valid     = CountW'(Idx) < count;
    assign range_end = entry_reg.start + srm_pkg::SEQ_W'(entry_reg.len);
    assign diff      = ctl.seq - entry_reg.start;
    assign hit_next  = valid && (ctl.seq >= entry_reg.start) && (ctl.seq < range_end);

    // at or after the insert position
    generate
        if (Idx == 0) begin : g_head
            assign ge = ctl.head_first;
        end else begin : g_body
            assign ge = ctl.head_first || !(valid && (ctl.seq > entry_reg.start));
        end
    endgenerate

    always_ff @(posedge clk) begin
        if (ctl.insert_en) begin
            if (prev_ge) begin
                entry_reg <= prev_entry;
            end else if (ge) begin
                entry_reg <= ctl.new_entry;
            end
        end
        if (ctl.lookup_en) begin
            mapped_reg <= entry_reg.dseq + srm_pkg::DSEQ_W'(diff);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hit_reg <= 1'b0;
        end else if (ctl.lookup_en) begin
            hit_reg <= hit_next;
        end
    end

    assign entry     = entry_reg;
    assign prior_out = prior_in | hit_reg;
    assign sel_value = (hit_reg && !prior_in) ? mapped_reg : '0;

endmodule

/* rtl/core/sequence_range_mapping_table.sv */
// sequence: start is taken in idle, the cell row compares in ST_EXEC, the first-hit
//   select across the row runs in ST_SEL, and done is then strobed from a register;
//   busy stays high until the FSM is back in idle, so no new item is taken before then
// reset: table empties, no result pending, busy low
// here the receiver cannot stall: done is a single-cycle strobe
module sequence_range_mapping_table #(
    parameter int MaxEntries = srm_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [srm_pkg::ACTION_W-1:0]      action,
    input  logic [srm_pkg::SEQ_W-1:0]         subflow_seq,
    input  logic [srm_pkg::DSEQ_W-1:0]        data_seq,
    input  logic [srm_pkg::LEN_W-1:0]         range_len,
    output logic                              done,
    output logic [srm_pkg::DSEQ_W-1:0]        mapped_seq,
    output logic                              found,
    output logic                              status,
    output logic [srm_pkg::COUNT_OUT_W-1:0]   entry_count
);

    localparam int CountW = $clog2(MaxEntries + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SEL  = 3'b100
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    srm_pkg::action_t                    action_reg;
    logic [srm_pkg::SEQ_W-1:0]           seq_reg;
    logic [srm_pkg::DSEQ_W-1:0]          dseq_reg;
    logic [srm_pkg::LEN_W-1:0]           len_reg;
    logic [CountW-1:0]                   count_reg;
    logic [CountW-1:0]                   count_next;
    logic                                drop_reg;
    logic                                full;
    logic                                accept;
    srm_pkg::cell_ctl_t                  ctl;

    logic                                done_reg;
    logic [srm_pkg::DSEQ_W-1:0]          mapped_seq_reg;
    logic                                found_reg;
    logic                                status_reg;
    logic [srm_pkg::COUNT_OUT_W-1:0]     entry_count_reg;

    srm_pkg::entry_t                     ent [MaxEntries];
    logic                                ge_chain [MaxEntries+1];
    logic                                prior [MaxEntries+1];
    logic [srm_pkg::DSEQ_W-1:0]          val [MaxEntries];
    logic [srm_pkg::DSEQ_W-1:0]          val_or;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign full   = (count_reg == CountW'(MaxEntries));

    always_comb begin
        ctl.insert_en            = (state_reg == ST_EXEC) && (action_reg == srm_pkg::ACT_INSERT)
                                   && !full;
        ctl.lookup_en            = (state_reg == ST_EXEC) && (action_reg == srm_pkg::ACT_LOOKUP);
        ctl.head_first           = (count_reg == '0) || (seq_reg < ent[0].start);
        ctl.seq                  = seq_reg;
        ctl.new_entry.start      = seq_reg;
        ctl.new_entry.dseq       = dseq_reg;
        ctl.new_entry.len        = len_reg;
    end

    assign ge_chain[0] = 1'b0;
    assign prior[0]    = 1'b0;

    generate
        for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
            srm_pkg::entry_t prev_ent;
            if (i == 0) begin : g_first
                assign prev_ent = ctl.new_entry;
            end else begin : g_rest
                assign prev_ent = ent[i-1];
            end
            srm_cell #(
                .Idx    (i),
                .CountW (CountW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .count      (count_reg),
                .prev_entry (prev_ent),
                .prev_ge    (ge_chain[i]),
                .ge         (ge_chain[i+1]),
                .entry      (ent[i]),
                .prior_in   (prior[i]),
                .prior_out  (prior[i+1]),
                .sel_value  (val[i])
            );
        end
    endgenerate

    // at most one cell drives a non-zero value
    always_comb begin
        val_or = '0;
        for (int i = 0; i < MaxEntries; i++) begin
            val_or = val_or | val[i];
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_SEL;
                case (action_reg)
                    srm_pkg::ACT_INSERT: begin
                        if (!full) begin
                            count_next = count_reg + CountW'(1);
                        end
                    end
                    srm_pkg::ACT_CLEAR: count_next = '0;
                    default:            count_next = count_reg;
                endcase
            end
            ST_SEL: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            drop_reg        <= 1'b0;
            done_reg        <= 1'b0;
            found_reg       <= 1'b0;
            status_reg      <= 1'b0;
            entry_count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == ST_SEL);
            if (state_reg == ST_EXEC) begin
                drop_reg <= (action_reg == srm_pkg::ACT_INSERT) && full;
            end
            if (state_reg == ST_SEL) begin
                found_reg       <= (action_reg == srm_pkg::ACT_LOOKUP) && prior[MaxEntries];
                status_reg      <= drop_reg;
                entry_count_reg <= srm_pkg::COUNT_OUT_W'(count_reg);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            action_reg <= srm_pkg::action_t'(action);
            seq_reg    <= subflow_seq;
            dseq_reg   <= data_seq;
            len_reg    <= range_len;
        end
        if (state_reg == ST_SEL) begin
            mapped_seq_reg <= (action_reg == srm_pkg::ACT_LOOKUP) ? val_or : '0;
        end
    end

    assign done        = done_reg;
    assign mapped_seq  = mapped_seq_reg;
    assign found       = found_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountW'(MaxEntries))
        else $error("entry count above table size");

    a_done_after_sel: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_SEL))
        else $error("result strobe without select cycle");

    a_found_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (action_reg == srm_pkg::ACT_LOOKUP))
        else $error("hit reported for a non-lookup item");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg) |->
            (action_reg == srm_pkg::ACT_INSERT) && (count_reg == CountW'(MaxEntries)))
        else $error("insert dropped while table not full");
`endif

endmodule
